/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

/* sv/drd_pkg.sv */
`default_nettype none

package drd_pkg;

	// Row layout
	localparam int MAX_CLASSES = 128;
	localparam int BOX_FIELDS  = 5;
	localparam int F_X         = 0;
	localparam int F_Y         = 1;
	localparam int F_W         = 2;
	localparam int F_H         = 3;
	localparam int F_OBJ       = 4;

	// Field widths
	localparam int VAL_W   = 32;
	localparam int THR_W   = 17;
	localparam int SCALE_W = 24;
	localparam int CNT_W   = 8;
	localparam int IDX_W   = 7;
	localparam int CONF_W  = 31;
	localparam int OUT_W   = 21;
	localparam int POS_W   = $clog2(MAX_CLASSES + BOX_FIELDS);

	// Box arithmetic widths: (2x - w) is 34 bits, times a 25-bit signed scale
	localparam int DIFF_W  = VAL_W + 2;
	localparam int PROD_W  = DIFF_W + SCALE_W + 1;
	localparam int WPROD_W = VAL_W + SCALE_W + 1;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_OBJ_THR   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCORE_THR = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_H_SCALE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_V_SCALE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CLS_CNT   = 3'd4;

	// Reset values
	localparam logic [THR_W-1:0]   OBJ_THR_RST   = 17'd26214;
	localparam logic [THR_W-1:0]   SCORE_THR_RST = 17'd13107;
	localparam logic [SCALE_W-1:0] SCALE_RST     = 24'd65536;
	localparam logic [CNT_W-1:0]   CLS_CNT_RST   = 8'd80;

	// Saturation limits and rounding-toward-zero biases
	localparam logic signed [PROD_W-1:0] SAT_MAX =
		{{(PROD_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
	localparam logic signed [PROD_W-1:0] SAT_MIN =
		{{(PROD_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};
	localparam logic signed [PROD_W-1:0] BIAS33 = {{(PROD_W-33){1'b0}}, {33{1'b1}}};
	localparam logic signed [PROD_W-1:0] BIAS32 = {{(PROD_W-32){1'b0}}, {32{1'b1}}};

	// Drop 33 or 32 fraction bits, truncating toward zero, then clamp to 21 bits
	function automatic logic signed [OUT_W-1:0] trunc_sat(
		input logic signed [PROD_W-1:0] p,
		input logic                     frac33
	);
		logic signed [PROD_W-1:0] bias;
		logic signed [PROD_W-1:0] sum;
		logic signed [PROD_W-1:0] q;
		bias = p[PROD_W-1] ? (frac33 ? BIAS33 : BIAS32) : '0;
		sum  = p + bias;
		q    = frac33 ? (sum >>> 33) : (sum >>> 32);
		if (q > SAT_MAX) begin
			trunc_sat = SAT_MAX[OUT_W-1:0];
		end else if (q < SAT_MIN) begin
			trunc_sat = SAT_MIN[OUT_W-1:0];
		end else begin
			trunc_sat = q[OUT_W-1:0];
		end
	endfunction

endpackage

`default_nettype wire

/* sv/detection_row_decode.sv */
`default_nettype none
`include "assert_macros.svh"

// Detection row decoder. Row values (signed Q16.16) arrive one per transfer on
// in_valid/in_ready in the order x, y, w, h, objectness, then class_count
// class scores; one value is taken per cycle. Box fields and a running argmax
// of the scores (first index wins a tie) are kept in registers. On the last
// value of a row a detection is emitted if objectness >= objectness_threshold
// and the best score > class_score_threshold, with the box converted to
// left/top/width/height in pixels, truncated toward zero and clamped to 21
// bits. Once the last value of its row is taken, a detection passes three
// result stages: center differences, then the four scale multipliers, then
// truncation and clamping. Values inside a row are always
// taken at one per cycle; the last value of a row waits only while all three
// result stages are full and out_ready is low. Configuration writes via
// cfg_write/cfg_index/cfg_data take effect on the next cycle; a class_count of
// zero acts as one and one above 128 acts as 128.
module detection_row_decode (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// configuration
	input  wire logic                                 cfg_write,
	input  wire logic [drd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [drd_pkg::CFG_DATA_W-1:0]       cfg_data,
	// row values
	input  wire logic                                 in_valid,
	output      logic                                 in_ready,
	input  wire logic signed [drd_pkg::VAL_W-1:0]     value,
	// detections
	output      logic                                 out_valid,
	input  wire logic                                 out_ready,
	output      logic [drd_pkg::IDX_W-1:0]            class_index,
	output      logic [drd_pkg::CONF_W-1:0]           confidence,
	output      logic signed [drd_pkg::OUT_W-1:0]     box_left,
	output      logic signed [drd_pkg::OUT_W-1:0]     box_top,
	output      logic signed [drd_pkg::OUT_W-1:0]     box_width,
	output      logic signed [drd_pkg::OUT_W-1:0]     box_height
);

	localparam int POS_W = drd_pkg::POS_W;
	localparam int VAL_W = drd_pkg::VAL_W;
	localparam int IDX_W = drd_pkg::IDX_W;

	// Configuration registers
	logic [drd_pkg::THR_W-1:0]   obj_thr_q;
	logic [drd_pkg::THR_W-1:0]   score_thr_q;
	logic [drd_pkg::SCALE_W-1:0] h_scale_q;
	logic [drd_pkg::SCALE_W-1:0] v_scale_q;
	logic [drd_pkg::CNT_W-1:0]   cls_cnt_q;

	// Row state
	logic [POS_W-1:0]        pos_q;
	logic signed [VAL_W-1:0] cx_q;
	logic signed [VAL_W-1:0] cy_q;
	logic signed [VAL_W-1:0] bw_q;
	logic signed [VAL_W-1:0] bh_q;
	logic signed [VAL_W-1:0] obj_q;
	logic signed [VAL_W-1:0] best_q;
	logic [IDX_W-1:0]        bidx_q;

	// Stage 1: finished row
	logic                                v1_s1;
	logic signed [drd_pkg::DIFF_W-1:0]   dx_s1;
	logic signed [drd_pkg::DIFF_W-1:0]   dy_s1;
	logic signed [VAL_W-1:0]             w_s1;
	logic signed [VAL_W-1:0]             h_s1;
	logic signed [VAL_W-1:0]             obj_s1;
	logic signed [VAL_W-1:0]             best_s1;
	logic [IDX_W-1:0]                    idx_s1;

	// Stage 2: scaled products
	logic                                v2_s2;
	logic signed [drd_pkg::PROD_W-1:0]   lx_s2;
	logic signed [drd_pkg::PROD_W-1:0]   ty_s2;
	logic signed [drd_pkg::WPROD_W-1:0]  wd_s2;
	logic signed [drd_pkg::WPROD_W-1:0]  ht_s2;
	logic [drd_pkg::CONF_W-1:0]          conf_s2;
	logic [IDX_W-1:0]                    idx_s2;

	// Stage 3: output register
	logic                                v3_s3;
	logic [IDX_W-1:0]                    idx_s3;
	logic [drd_pkg::CONF_W-1:0]          conf_s3;
	logic signed [drd_pkg::OUT_W-1:0]    left_s3;
	logic signed [drd_pkg::OUT_W-1:0]    top_s3;
	logic signed [drd_pkg::OUT_W-1:0]    width_s3;
	logic signed [drd_pkg::OUT_W-1:0]    height_s3;

	logic                    in_xfer;
	logic [POS_W-1:0]        n_eff;
	logic [POS_W-1:0]        last_pos;
	logic                    row_end;
	logic [IDX_W-1:0]        cls_idx;
	logic                    take_best;
	logic signed [VAL_W-1:0] best_n;
	logic [IDX_W-1:0]        bidx_n;
	logic                    en1;
	logic                    en2;
	logic                    en3;
	logic                    keep;

	// Configuration writes; out-of-range indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obj_thr_q   <= drd_pkg::OBJ_THR_RST;
			score_thr_q <= drd_pkg::SCORE_THR_RST;
			h_scale_q   <= drd_pkg::SCALE_RST;
			v_scale_q   <= drd_pkg::SCALE_RST;
			cls_cnt_q   <= drd_pkg::CLS_CNT_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				drd_pkg::REG_OBJ_THR:   obj_thr_q   <= cfg_data[drd_pkg::THR_W-1:0];
				drd_pkg::REG_SCORE_THR: score_thr_q <= cfg_data[drd_pkg::THR_W-1:0];
				drd_pkg::REG_H_SCALE:   h_scale_q   <= cfg_data[drd_pkg::SCALE_W-1:0];
				drd_pkg::REG_V_SCALE:   v_scale_q   <= cfg_data[drd_pkg::SCALE_W-1:0];
				drd_pkg::REG_CLS_CNT:   cls_cnt_q   <= cfg_data[drd_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective class count and last position of the row
	always_comb begin
		if (cls_cnt_q == '0) begin
			n_eff = POS_W'(1);
		end else if (int'(cls_cnt_q) > drd_pkg::MAX_CLASSES) begin
			n_eff = POS_W'(drd_pkg::MAX_CLASSES);
		end else begin
			n_eff = POS_W'(cls_cnt_q);
		end
		last_pos = n_eff + POS_W'(drd_pkg::BOX_FIELDS - 1);
		row_end  = (pos_q >= last_pos);
	end

	// Pipeline advance: a stage moves when it is empty or its successor moves
	assign en3      = !v3_s3 || out_ready;
	assign en2      = !v2_s2 || en3;
	assign en1      = !v1_s1 || en2;
	assign in_ready = en1 || !row_end;
	assign in_xfer  = in_valid && in_ready;

	// Running argmax, first index wins ties
	always_comb begin
		cls_idx   = IDX_W'(pos_q - POS_W'(drd_pkg::BOX_FIELDS));
		take_best = (pos_q == POS_W'(drd_pkg::BOX_FIELDS)) || (value > best_q);
		best_n    = take_best ? value : best_q;
		bidx_n    = take_best ? cls_idx : bidx_q;
	end

	// Row state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			cx_q   <= '0;
			cy_q   <= '0;
			bw_q   <= '0;
			bh_q   <= '0;
			obj_q  <= '0;
			best_q <= '0;
			bidx_q <= '0;
		end else if (in_xfer) begin
			if (row_end) begin
				pos_q  <= '0;
				cx_q   <= '0;
				cy_q   <= '0;
				bw_q   <= '0;
				bh_q   <= '0;
				obj_q  <= '0;
				best_q <= '0;
				bidx_q <= '0;
			end else begin
				pos_q <= pos_q + 1'b1;
				case (pos_q)
					POS_W'(drd_pkg::F_X):   cx_q  <= value;
					POS_W'(drd_pkg::F_Y):   cy_q  <= value;
					POS_W'(drd_pkg::F_W):   bw_q  <= value;
					POS_W'(drd_pkg::F_H):   bh_q  <= value;
					POS_W'(drd_pkg::F_OBJ): obj_q <= value;
					default: begin
						best_q <= best_n;
						bidx_q <= bidx_n;
					end
				endcase
			end
		end
	end

	// Stage 1: capture a finished row (the last value is always a class score)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
		end else if (en1) begin
			v1_s1 <= in_xfer && row_end;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_xfer && row_end) begin
			dx_s1   <= {cx_q[VAL_W-1], cx_q, 1'b0} - {{2{bw_q[VAL_W-1]}}, bw_q};
			dy_s1   <= {cy_q[VAL_W-1], cy_q, 1'b0} - {{2{bh_q[VAL_W-1]}}, bh_q};
			w_s1    <= bw_q;
			h_s1    <= bh_q;
			obj_s1  <= obj_q;
			best_s1 <= best_n;
			idx_s1  <= bidx_n;
		end
	end

	// Stage 2: threshold test and scale multiplies
	assign keep = (obj_s1 >= $signed({{(VAL_W - drd_pkg::THR_W){1'b0}}, obj_thr_q})) &&
		(best_s1 > $signed({{(VAL_W - drd_pkg::THR_W){1'b0}}, score_thr_q}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_s2 <= 1'b0;
		end else if (en2) begin
			v2_s2 <= v1_s1 && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			lx_s2   <= dx_s1 * $signed({1'b0, h_scale_q});
			ty_s2   <= dy_s1 * $signed({1'b0, v_scale_q});
			wd_s2   <= w_s1 * $signed({1'b0, h_scale_q});
			ht_s2   <= h_s1 * $signed({1'b0, v_scale_q});
			conf_s2 <= obj_s1[drd_pkg::CONF_W-1:0];
			idx_s2  <= idx_s1;
		end
	end

	// Stage 3: truncate toward zero, clamp, hold for the output transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_s3 <= 1'b0;
		end else if (en3) begin
			v3_s3 <= v2_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			idx_s3    <= idx_s2;
			conf_s3   <= conf_s2;
			left_s3   <= drd_pkg::trunc_sat(lx_s2, 1'b1);
			top_s3    <= drd_pkg::trunc_sat(ty_s2, 1'b1);
			width_s3  <= drd_pkg::trunc_sat(drd_pkg::PROD_W'(wd_s2), 1'b0);
			height_s3 <= drd_pkg::trunc_sat(drd_pkg::PROD_W'(ht_s2), 1'b0);
		end
	end

	assign out_valid   = v3_s3;
	assign class_index = idx_s3;
	assign confidence  = conf_s3;
	assign box_left    = left_s3;
	assign box_top     = top_s3;
	assign box_width   = width_s3;
	assign box_height  = height_s3;

	// Checks
	`ASSERT_NXT(a_row_end_loads, clk, arst_n, in_xfer && row_end, v1_s1)
	`ASSERT_NXT(a_pos_advances, clk, arst_n, in_xfer && !row_end,
		pos_q == POS_W'($past(pos_q) + 1'b1))
	`ASSERT_NXT(a_row_cleared, clk, arst_n, in_xfer && row_end,
		pos_q == '0 && best_q == '0 && bidx_q == '0)
	`ASSERT_IMP(a_conf_meets_thr, clk, arst_n, v3_s3,
		{1'b0, conf_s3} >= {{(VAL_W - drd_pkg::THR_W){1'b0}}, obj_thr_q})

endmodule

`default_nettype wire
